// ===== rtl/core/spsc_pkg.sv =====
// shared constants and types for the stack pop sequence checker
package spsc_pkg;

	localparam int MAX_DEPTH_DEF = 1024;
	localparam int VALUE_W = 11;
	localparam int CFG_W = 11;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SEQ_LEN = 1'b1;

	localparam logic [CFG_W-1:0] CAPACITY_RST = 11'd5;
	localparam logic [CFG_W-1:0] SEQ_LEN_RST = 11'd7;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_CHECK  = 4'b0010,
		ST_LOAD   = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

endpackage

// ===== rtl/core/spsc_ram.sv =====
// generic single write port ram with registered read
module spsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/stack_pop_sequence_checker.sv =====
// stack pop order checker: top level with sequencer and stack memory
//
//  channel   | signals                        | role
//  ----------+--------------------------------+------------------------------
//  cfg       | cfg_we, cfg_index, cfg_data    | capacity / sequence length
//  in        | in_valid, in_ready, pop_value  | one popped value per beat
//  out       | out_valid, out_ready, possible | verdict after the n-th beat
//
// an item passes from idle to check, which pushes values until the top matches;
// a pop that leaves the stack non-empty goes through load (the new top is read
// back from the stack ram) before finish; items after a failure go from idle
// straight to finish; the push loop goes through the single ram write port
// arst_n clears the sequencer and sets the config registers to their reset values; the stack ram is not cleared
// the verdict sits in an output register, so a stalled out beat only holds
// the sequencer when the next verdict is due
module stack_pop_sequence_checker #(
	parameter int MAX_DEPTH = spsc_pkg::MAX_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [spsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [spsc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [spsc_pkg::VALUE_W-1:0]   pop_value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           possible
);

	import spsc_pkg::*;

	localparam int AW = $clog2(MAX_DEPTH);
	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int CW = (DW > CFG_W) ? DW : CFG_W;
	localparam int NW = VALUE_W + 1;

	state_t              state_q;
	logic [CFG_W-1:0]    cap_q;
	logic [CFG_W-1:0]    len_q;
	logic [VALUE_W-1:0]  val_q;
	logic [VALUE_W-1:0]  top_q;
	logic [DW-1:0]       depth_q;
	logic [NW-1:0]       np_q;
	logic [CFG_W-1:0]    items_q;
	logic                failed_q;
	logic                out_valid_q;
	logic                possible_q;

	logic                top_hit;
	logic                can_push;
	logic                stk_full;
	logic                wr_en;
	logic                rd_en;
	logic [DW-1:0]       depth_m2;
	logic [VALUE_W-1:0]  rd_data;
	logic                seq_done;
	logic                out_load;

	assign top_hit  = (depth_q != '0) && (top_q == val_q);
	assign can_push = np_q <= {1'b0, len_q};
	assign stk_full = (depth_q == DW'(MAX_DEPTH)) || (CW'(depth_q) >= CW'(cap_q));
	assign depth_m2 = depth_q - DW'(2);

	assign wr_en = (state_q == ST_CHECK) && !top_hit && can_push && !stk_full;
	assign rd_en = (state_q == ST_CHECK) && top_hit && (depth_q >= DW'(2));

	assign seq_done = ({1'b0, items_q} + NW'(1)) >= {1'b0, len_q};
	assign out_load = (state_q == ST_FINISH) && seq_done && (!out_valid_q || out_ready);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign possible  = possible_q;

	spsc_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (MAX_DEPTH)
	) u_stack (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (depth_q[AW-1:0]),
		.wr_data (np_q[VALUE_W-1:0]),
		.rd_en   (rd_en),
		.rd_addr (depth_m2[AW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAPACITY_RST;
			len_q <= SEQ_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CAPACITY: cap_q <= cfg_data;
				REG_SEQ_LEN:  len_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			val_q <= pop_value;
		end
		if (wr_en) begin
			top_q <= np_q[VALUE_W-1:0];
		end else if (state_q == ST_LOAD) begin
			top_q <= rd_data;
		end
		if (out_load) begin
			possible_q <= !failed_q && (depth_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			depth_q     <= '0;
			np_q        <= NW'(1);
			items_q     <= '0;
			failed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= failed_q ? ST_FINISH : ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (top_hit) begin
						// pop; new top comes back from the ram when one remains
						depth_q <= depth_q - DW'(1);
						state_q <= rd_en ? ST_LOAD : ST_FINISH;
					end else if (wr_en) begin
						depth_q <= depth_q + DW'(1);
						np_q    <= np_q + NW'(1);
					end else begin
						// stack full, or value buried or out of range
						failed_q <= 1'b1;
						state_q  <= ST_FINISH;
					end
				end
				ST_LOAD: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!seq_done) begin
						items_q <= items_q + CFG_W'(1);
						state_q <= ST_IDLE;
					end else if (out_load) begin
						depth_q     <= '0;
						np_q        <= NW'(1);
						items_q     <= '0;
						failed_q    <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(MAX_DEPTH))
		else $error("stack depth above memory size");

	a_pushed_cover_stack: assert property (@(posedge clk) disable iff (!arst_n)
		np_q > NW'(depth_q))
		else $error("stack holds more entries than values pushed");

	a_pop_reload: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> (state_q == ST_LOAD) && (depth_q != '0))
		else $error("pop with entries left did not reload the top");

	a_fail_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(failed_q) |-> $past(out_load))
		else $error("failure cleared without a verdict");

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for the stack pop sequence checker
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import spsc_pkg::*;

	localparam int TB_DEPTH = MAX_DEPTH_DEF;
	localparam int SETTLE_CYCLES = TB_DEPTH + 100;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 20000;
	localparam int RAND_ITEMS = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_CAPACITY;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [VALUE_W-1:0] pop_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic possible;

	stack_pop_sequence_checker #(.MAX_DEPTH(TB_DEPTH)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pop_value(pop_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.possible(possible)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// shadow of the checker state
	logic [CFG_W-1:0] cap_shadow = CAPACITY_RST;
	logic [CFG_W-1:0] len_shadow = SEQ_LEN_RST;
	int unsigned stack_shadow [TB_DEPTH];
	int unsigned depth_shadow = 0;
	int unsigned next_push = 1;
	bit seq_failed = 1'b0;
	int unsigned seen_count = 0;

	logic verdict_due [$];
	logic [VALUE_W-1:0] pop_feed [$];
	logic [VALUE_W-1:0] seq_buf [$];

	int errors = 0;
	bit in_taken = 1'b0;
	int in_gap = 0;
	int rx_gap = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	logic want;

	function automatic bit value_on_top(input int unsigned v);
		return depth_shadow > 0 && stack_shadow[depth_shadow - 1] == v;
	endfunction

	function void track_pop(input logic [VALUE_W-1:0] v);
		int unsigned lim;
		lim = (cap_shadow < TB_DEPTH) ? cap_shadow : TB_DEPTH;
		if (!seq_failed) begin
			while (!value_on_top(v) && next_push <= len_shadow) begin
				if (depth_shadow >= lim) begin
					seq_failed = 1'b1;
					break;
				end
				stack_shadow[depth_shadow] = next_push;
				depth_shadow++;
				next_push++;
			end
			if (!seq_failed) begin
				if (value_on_top(v))
					depth_shadow--;
				else
					seq_failed = 1'b1;
			end
		end
		seen_count++;
		if (seen_count >= len_shadow) begin
			verdict_due.push_back(!seq_failed && depth_shadow == 0);
			depth_shadow = 0;
			next_push = 1;
			seq_failed = 1'b0;
			seen_count = 0;
		end
	endfunction

	// sender: one value per beat
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			in_taken = 1'b0;
			if (in_gap != 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pop_feed.size() != 0) begin
				pop_value <= pop_feed.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver ready, with an occasional long hold-off
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (rx_gap != 0) begin
			rx_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			track_pop(pop_value);
			in_taken = 1'b1;
			in_gap = tx_steady ? 0 : $urandom_range(0, 6);
		end
		if (arst_n && out_valid && out_ready) begin
			if (verdict_due.size() == 0) begin
				$error("possible: expected none, actual %0d", possible);
				errors++;
			end else begin
				want = verdict_due.pop_front();
				if (possible !== want) begin
					$error("possible: expected %0d, actual %0d", want, possible);
					errors++;
				end
			end
			rx_gap = rx_steady ? 0 : $urandom_range(0, 6);
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
		end
		$display("Verification failed");
		$finish;
	end

	task automatic drain();
		while (pop_feed.size() != 0 || in_valid || verdict_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_CAPACITY)
			cap_shadow = val;
		else
			len_shadow = val;
	endtask

	// the block may still be busy on a beat that gives no verdict
	task automatic retune(input logic [CFG_W-1:0] cap, input logic [CFG_W-1:0] len);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_CAPACITY, cap);
		write_reg(REG_SEQ_LEN, len);
	endtask

	task automatic load_buf();
		foreach (seq_buf[i])
			pop_feed.push_back(seq_buf[i]);
	endtask

	// random legal pop order for n values through a stack of cap entries; with cap zero the values are random
	task automatic make_valid_order(input int n, input int cap);
		int unsigned stk [$];
		int unsigned nxt;
		int lim;
		nxt = 1;
		lim = (cap < TB_DEPTH) ? cap : TB_DEPTH;
		seq_buf.delete();
		while (seq_buf.size() < n) begin
			if (nxt <= n && stk.size() < lim && (stk.size() == 0 || $urandom_range(0, 1)))
			begin
				stk.push_back(nxt);
				nxt++;
			end else if (stk.size() != 0) begin
				seq_buf.push_back(VALUE_W'(stk.pop_back()));
			end else begin
				seq_buf.push_back(VALUE_W'($urandom_range(1, n)));
			end
		end
	endtask

	initial begin : stimulus
		int cap;
		int len;
		int kind;
		int round;
		int rand_count;
		int a;
		int b;
		logic [VALUE_W-1:0] tmp;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset setting, oversized capacity, bad values
		seq_buf = '{3, 2, 1, 5, 4, 7, 6};
		load_buf();
		retune(2047, 3);
		seq_buf = '{3, 2, 1, 2047, 0, 1};
		load_buf();
		retune(0, 2);
		seq_buf = '{1, 2};
		load_buf();
		retune(1, 1);
		seq_buf = '{1, 0};
		load_buf();
		retune(1024, 0);
		seq_buf = '{5, 1};
		load_buf();
		// overflow, then beats after the failure
		retune(3, 4);
		seq_buf = '{4, 3, 2, 1};
		load_buf();
		// shorten the length while a sequence is open
		retune(5, 6);
		seq_buf = '{2, 1};
		load_buf();
		retune(5, 2);
		seq_buf = '{3};
		load_buf();

		// deepest legal stack
		retune(1024, 1024);
		seq_buf.delete();
		for (int v = 1024; v >= 1; v--)
			seq_buf.push_back(VALUE_W'(v));
		load_buf();
		// full stack overflow with values past the depth, then cut short
		retune(2047, 2047);
		seq_buf = '{1, 2000};
		load_buf();
		retune(5, 1);
		seq_buf = '{3};
		load_buf();

		round = 0;
		rand_count = 0;
		cap = 5;
		len = 1;
		while (rand_count < RAND_ITEMS) begin
			if (round % 8 == 0) begin
				case ($urandom_range(0, 9))
					0: cap = 0;
					1: cap = 1;
					2: cap = 2047;
					3: cap = 1024;
					default: cap = $urandom_range(1, 8);
				endcase
				case ($urandom_range(0, 14))
					0: len = 0;
					1: len = 1;
					2, 3: len = $urandom_range(13, 40);
					default: len = $urandom_range(2, 12);
				endcase
				retune(CFG_W'(cap), CFG_W'(len));
			end
			@(negedge clk);
			tx_steady = ($urandom_range(0, 4) == 0);
			rx_steady = ($urandom_range(0, 4) == 0);
			if (round == 5) begin
				// receiver stalls while the sender keeps pushing beats
				@(posedge clk);
				hold_req = 1'b1;
				tx_steady = 1'b1;
			end
			if (round % 37 == 10)
				drain();

			kind = $urandom_range(0, 99);
			if (len == 0) begin
				seq_buf.delete();
				repeat ($urandom_range(1, 3))
					seq_buf.push_back(VALUE_W'($urandom_range(0, 2047)));
			end else if (kind < 70) begin
				make_valid_order(len, cap);
			end else if (kind < 85) begin
				make_valid_order(len, cap);
				a = $urandom_range(0, len - 1);
				b = $urandom_range(0, len - 1);
				case ($urandom_range(0, 2))
					0: begin
						tmp = seq_buf[a];
						seq_buf[a] = seq_buf[b];
						seq_buf[b] = tmp;
					end
					1: seq_buf[a] = VALUE_W'($urandom_range(0, 2047));
					default: seq_buf[a] = VALUE_W'($urandom_range(0, len + 1));
				endcase
			end else begin
				seq_buf.delete();
				repeat (len) begin
					if ($urandom_range(0, 1))
						seq_buf.push_back(VALUE_W'($urandom_range(0, 2047)));
					else
						seq_buf.push_back(VALUE_W'($urandom_range(0, len + 1)));
				end
			end
			load_buf();
			rand_count += seq_buf.size();
			round++;
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
